// ===== rtl/mwoc_pkg.sv =====
// Shared constants and types for the max window ones counter.
// No dependencies.
package mwoc_pkg;

  localparam int MAX_COLS   = 32;
  localparam int WIN        = 4;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int HIST_W     = WIN - 1;
  localparam int CSUM_W     = $clog2(WIN + 1);
  localparam int SUM_W      = $clog2(WIN * WIN + 1);
  localparam int ROW_W      = $clog2(WIN);
  localparam int CFG_W      = 6;
  localparam int OUT_W      = 5;
  localparam int CMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(21);

  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [CSUM_W-1:0] csum_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

// ===== rtl/mwoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/max_window_ones_count.sv =====
// Top level of the max window ones counter: line store RAM, column sum window, running max.
// Depends on mwoc_pkg and mwoc_ram.
//
// Takes one grid cell per clock in raster order when in_stall is low and, on the cell marked
// end_of_grid, returns the largest count of ones over all full 4x4 windows (zero if none fit).
// The previous three rows of each column live in a 32-entry RAM read one column ahead of the
// incoming cell, with forwarding when the next cell falls in the same column; cells may
// therefore arrive back to back. The result is captured in an output register when the final
// cell is accepted; only a final cell is held off while an earlier result is still stalled.
// State returns to reset after each grid; cols keeps its value.
module max_window_ones_count (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mwoc_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cell_bit,
  input  logic                        in_end_of_grid,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mwoc_pkg::OUT_W-1:0]  out_max_ones
);

  logic [mwoc_pkg::CFG_W-1:0]  cols_r;
  logic [mwoc_pkg::COL_W-1:0]  col_pos_r, col_pos_nxt;
  logic [mwoc_pkg::ROW_W-1:0]  row_pos_r, row_pos_nxt;
  mwoc_pkg::sum_t              best_r, best_nxt;
  mwoc_pkg::csum_t             win_r [mwoc_pkg::WIN];
  logic [mwoc_pkg::MAX_COLS-1:0] valid_r;
  logic                        fwd_r;
  mwoc_pkg::hist_t             fwd_data_r;
  logic                        out_valid_r;
  logic [mwoc_pkg::OUT_W-1:0]  out_max_ones_r;

  logic                        in_acc;
  logic [mwoc_pkg::CMP_W-1:0]  width;
  logic [mwoc_pkg::CMP_W-1:0]  col_inc;
  logic                        col_wrap;
  logic [mwoc_pkg::COL_W-1:0]  rd_addr;
  mwoc_pkg::hist_t             ram_rd_data;
  mwoc_pkg::hist_t             hist;
  mwoc_pkg::hist_t             hist_new;
  mwoc_pkg::csum_t             csum;
  mwoc_pkg::sum_t              win_sum;
  logic                        full_win;

  function automatic mwoc_pkg::csum_t popcount(input mwoc_pkg::hist_t v);
    mwoc_pkg::csum_t n;
    n = '0;
    for (int i = 0; i < mwoc_pkg::HIST_W; i++) begin
      n = n + mwoc_pkg::csum_t'(v[i]);
    end
    return n;
  endfunction

  assign in_stall = out_valid_r && out_stall && in_end_of_grid;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (cols_r == '0) begin
      width = mwoc_pkg::CMP_W'(1);
    end else if (mwoc_pkg::CMP_W'(cols_r) > mwoc_pkg::CMP_W'(mwoc_pkg::MAX_COLS)) begin
      width = mwoc_pkg::CMP_W'(mwoc_pkg::MAX_COLS);
    end else begin
      width = mwoc_pkg::CMP_W'(cols_r);
    end
  end

  assign col_inc  = mwoc_pkg::CMP_W'(col_pos_r) + mwoc_pkg::CMP_W'(1);
  assign col_wrap = col_inc >= width;

  always_comb begin
    if (!valid_r[col_pos_r]) begin
      hist = '0;
    end else if (fwd_r) begin
      hist = fwd_data_r;
    end else begin
      hist = ram_rd_data;
    end
  end

  assign hist_new = {hist[mwoc_pkg::HIST_W-2:0], in_cell_bit};
  assign csum     = popcount(hist) + mwoc_pkg::csum_t'(in_cell_bit);
  assign full_win = (row_pos_r == mwoc_pkg::ROW_W'(mwoc_pkg::WIN - 1)) &&
                    (mwoc_pkg::CMP_W'(col_pos_r) >= mwoc_pkg::CMP_W'(mwoc_pkg::WIN - 1));

  always_comb begin
    win_sum = mwoc_pkg::sum_t'(csum);
    for (int i = 1; i < mwoc_pkg::WIN; i++) begin
      win_sum = win_sum + mwoc_pkg::sum_t'(win_r[i]);
    end
  end

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    best_nxt    = best_r;
    if (in_acc) begin
      if (full_win && win_sum > best_r) begin
        best_nxt = win_sum;
      end
      if (col_wrap) begin
        col_pos_nxt = '0;
        if (row_pos_r != mwoc_pkg::ROW_W'(mwoc_pkg::WIN - 1)) begin
          row_pos_nxt = row_pos_r + mwoc_pkg::ROW_W'(1);
        end
      end else begin
        col_pos_nxt = col_inc[mwoc_pkg::COL_W-1:0];
      end
      if (in_end_of_grid) begin
        col_pos_nxt = '0;
        row_pos_nxt = '0;
        best_nxt    = '0;
      end
    end
  end

  // Line store is read one cell ahead; same-column reuse is forwarded.
  assign rd_addr = col_pos_nxt;

  mwoc_ram #(
    .WIDTH (mwoc_pkg::HIST_W),
    .DEPTH (mwoc_pkg::MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_pos_r),
    .wr_data (hist_new),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= mwoc_pkg::COLS_RESET;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      best_r      <= '0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mwoc_pkg::WIN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cols_r <= cfg_wr_data;
      end
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      best_r    <= best_nxt;
      fwd_r     <= in_acc && (rd_addr == col_pos_r);
      if (in_acc) begin
        if (in_end_of_grid) begin
          valid_r <= '0;
          for (int i = 0; i < mwoc_pkg::WIN; i++) begin
            win_r[i] <= '0;
          end
        end else begin
          valid_r[col_pos_r] <= 1'b1;
          for (int i = 0; i < mwoc_pkg::WIN - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[mwoc_pkg::WIN-1] <= csum;
        end
      end
      if (in_acc && in_end_of_grid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= hist_new;
    if (in_acc && in_end_of_grid) begin
      out_max_ones_r <= mwoc_pkg::OUT_W'(best_nxt == '0 && full_win && win_sum > best_r ?
                                         win_sum : (full_win && win_sum > best_r ?
                                         win_sum : best_r));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_max_ones = out_max_ones_r;

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= mwoc_pkg::sum_t'(mwoc_pkg::WIN * mwoc_pkg::WIN))
    else $error("running max above window size");

  a_grid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_grid |=> col_pos_r == '0 && row_pos_r == '0 && best_r == '0 &&
                                 valid_r == '0)
    else $error("grid state not cleared after final cell");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(in_acc))
    else $error("forwarding without a write");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_end_of_grid))
    else $error("result without a final cell");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_end_of_grid && col_wrap &&
    row_pos_r != mwoc_pkg::ROW_W'(mwoc_pkg::WIN - 1)
    |=> row_pos_r == $past(row_pos_r) + mwoc_pkg::ROW_W'(1))
    else $error("row counter missed a row end");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for max_window_ones_count: streams binary grids, predicts the largest 4x4 ones count.
// Depends on mwoc_pkg and the max_window_ones_count RTL; self-contained otherwise.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [mwoc_pkg::CFG_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cell_bit;
  logic                       in_end_of_grid;
  logic                       out_valid;
  logic                       out_stall;
  logic [mwoc_pkg::OUT_W-1:0] out_max_ones;

  max_window_ones_count dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cell_bit    (in_cell_bit),
    .in_end_of_grid (in_end_of_grid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_max_ones   (out_max_ones)
  );

  typedef struct {
    bit                         is_cfg;
    logic [mwoc_pkg::CFG_W-1:0] cols_val;
    logic                       cell_val;
    logic                       last;
    bit                         fixed;
    logic [mwoc_pkg::OUT_W-1:0] ones;
  } grid_step_t;

  grid_step_t                 directed_cells[$];
  logic [mwoc_pkg::OUT_W-1:0] max_ones_q[$];
  logic [mwoc_pkg::OUT_W-1:0] want_ones;

  // grid tracker state
  logic [mwoc_pkg::CFG_W-1:0] row_len;
  mwoc_pkg::hist_t            line_hist[mwoc_pkg::MAX_COLS];
  mwoc_pkg::csum_t            col_sums[mwoc_pkg::WIN];
  logic [mwoc_pkg::COL_W-1:0] col_idx;
  logic [mwoc_pkg::ROW_W-1:0] rows_done;
  mwoc_pkg::sum_t             best_ones;

  int errors     = 0;
  int cells_sent = 0;
  int grids_done = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic clear_tracker();
    foreach (line_hist[i]) line_hist[i] = '0;
    foreach (col_sums[i]) col_sums[i] = '0;
    col_idx   = '0;
    rows_done = '0;
    best_ones = '0;
  endtask

  task automatic step_window(input logic b, input logic e,
                             output logic [mwoc_pkg::OUT_W-1:0] grid_max);
    int              width;
    int              next_col;
    int              total;
    mwoc_pkg::hist_t h;
    width = int'(row_len);
    if (width < 1) width = 1;
    if (width > mwoc_pkg::MAX_COLS) width = mwoc_pkg::MAX_COLS;
    h = line_hist[col_idx];
    for (int i = 0; i < mwoc_pkg::WIN - 1; i++) col_sums[i] = col_sums[i + 1];
    col_sums[mwoc_pkg::WIN - 1] = mwoc_pkg::csum_t'($countones(h) + b);
    if (rows_done >= mwoc_pkg::WIN - 1 && col_idx >= mwoc_pkg::WIN - 1) begin
      total = 0;
      for (int i = 0; i < mwoc_pkg::WIN; i++) total += col_sums[i];
      if (total > best_ones) best_ones = mwoc_pkg::sum_t'(total);
    end
    line_hist[col_idx] = {h[mwoc_pkg::HIST_W-2:0], b};
    next_col = col_idx + 1;
    if (next_col >= width) begin
      next_col = 0;
      if (rows_done < mwoc_pkg::WIN - 1) rows_done = rows_done + 1'b1;
    end
    col_idx  = mwoc_pkg::COL_W'(next_col);
    grid_max = mwoc_pkg::OUT_W'(best_ones);
    if (e) clear_tracker();
  endtask

  function automatic void add_step(int is_cfg, int cols_val, int cell_val,
                                   int last, int fixed, int ones);
    grid_step_t s;
    s.is_cfg   = (is_cfg != 0);
    s.cols_val = mwoc_pkg::CFG_W'(cols_val);
    s.cell_val = (cell_val != 0);
    s.last     = (last != 0);
    s.fixed    = (fixed != 0);
    s.ones     = mwoc_pkg::OUT_W'(ones);
    directed_cells.push_back(s);
  endfunction

  task automatic send_cell(input logic b, input logic e, input bit fixed,
                           input logic [mwoc_pkg::OUT_W-1:0] ones);
    logic [mwoc_pkg::OUT_W-1:0] grid_max;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cell_bit    <= b;
    in_end_of_grid <= e;
    do @(posedge clk); while (!(in_valid && !in_stall));
    step_window(b, e, grid_max);
    cells_sent++;
    if (e) begin
      max_ones_q.push_back(fixed ? ones : grid_max);
      grids_done++;
    end
  endtask

  // block must be drained before the width register changes
  task automatic write_cols(input logic [mwoc_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (max_ones_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    row_len = v;
  endtask

  initial begin : stimulus
    int n;
    int dens;
    int split;
    int eff;
    int cv;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_cell_bit    = 1'b0;
    in_end_of_grid = 1'b0;
    row_len        = mwoc_pkg::COLS_RESET;
    clear_tracker();

    // reset width, lone cell: no window
    add_step(0, 0, 1, 1, 1, 0);
    // minimum width, full grid of ones
    add_step(1, 4, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) add_step(0, 0, 1, i == 15, i == 15, 16);
    // width zero clamps to one column
    add_step(1, 0, 0, 0, 0, 0);
    add_step(0, 0, 1, 0, 0, 0);
    add_step(0, 0, 1, 1, 1, 0);
    // widths above range clamp to 32
    add_step(1, 63, 0, 0, 0, 0);
    add_step(0, 0, 1, 1, 1, 0);
    add_step(1, 32, 0, 0, 0, 0);
    add_step(0, 0, 0, 1, 1, 0);
    // width below window size never closes a window
    add_step(1, 3, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) add_step(0, 0, 1, i == 3, i == 3, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cells[i]) begin
      if (directed_cells[i].is_cfg) write_cols(directed_cells[i].cols_val);
      else send_cell(directed_cells[i].cell_val, directed_cells[i].last,
                     directed_cells[i].fixed, directed_cells[i].ones);
    end

    // output held off while small grids keep coming
    write_cols(mwoc_pkg::CFG_W'(4));
    hold_req = 1'b1;
    for (int g = 0; g < 4; g++) begin
      dens = $urandom_range(0, 4);
      for (int k = 0; k < 16; k++) send_cell($urandom_range(0, 3) < dens, k == 15, 1'b0, '0);
    end

    while (cells_sent < 1800 || grids_done < 40) begin
      if (cells_sent >= 1500) calm = 1'b1;
      if ($urandom_range(0, 4) != 0) cv = $urandom_range(4, 8);
      else cv = $urandom_range(0, 63);
      write_cols(mwoc_pkg::CFG_W'(cv));
      eff = (cv < 1) ? 1 : (cv > mwoc_pkg::MAX_COLS) ? mwoc_pkg::MAX_COLS : cv;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 20);
      else n = eff * $urandom_range(3, 6) + $urandom_range(0, eff - 1);
      dens  = $urandom_range(0, 4);
      split = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : 0;
      for (int k = 0; k < n; k++) begin
        if (split != 0 && k == split) write_cols(mwoc_pkg::CFG_W'($urandom_range(0, 63)));
        send_cell($urandom_range(0, 3) < dens, k == n - 1, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (max_ones_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (max_ones_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual max_ones %0d",
                 $time, out_max_ones);
      end else begin
        want_ones = max_ones_q.pop_front();
        if (out_max_ones !== want_ones) begin
          errors++;
          $display("%0t: max_ones mismatch, expected %0d, actual %0d",
                   $time, want_ones, out_max_ones);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule
